// ----- src/sortpq_pkg.sv -----
// shared types and constants for the sorted priority queue
// used by sortpq_ctrl, sortpq_dpath and sorted_priority_queue; no dependencies
package sortpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_EXTRACT,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        t_op  op;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic cmd_extract;
        logic full;
        logic empty;
    } t_stat;

endpackage

// ----- src/sortpq_ctrl.sv -----
// controller for the sorted priority queue: handshake and operation sequencing
// depends on sortpq_pkg
module sortpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  sortpq_pkg::t_stat i_stat,
    output sortpq_pkg::t_ctrl o_ctrl
);

    sortpq_pkg::t_state r_state, n_state;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sortpq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        o_ctrl.op   = sortpq_pkg::OP_INSERT;
        unique case (r_state)
            sortpq_pkg::S_IDLE: begin
                // the output register must be free by the time the operation ends
                o_s_tready  = i_rst_n && (!r_out_valid || i_m_tready);
                o_ctrl.load = i_s_tvalid && o_s_tready;
                if (o_ctrl.load) begin
                    n_state = sortpq_pkg::S_EXEC;
                end
            end
            sortpq_pkg::S_EXEC: begin
                o_ctrl.exec = 1'b1;
                if (i_stat.cmd_extract) begin
                    o_ctrl.op = i_stat.empty ? sortpq_pkg::OP_REJECT_EMPTY
                                             : sortpq_pkg::OP_EXTRACT;
                end else begin
                    o_ctrl.op = i_stat.full ? sortpq_pkg::OP_REJECT_FULL
                                            : sortpq_pkg::OP_INSERT;
                end
                n_state = sortpq_pkg::S_IDLE;
            end
            default: n_state = sortpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_ctrl.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ----- src/sortpq_dpath.sv -----
// datapath for the sorted priority queue: shift-register sorted array,
// entry count and result register; depends on sortpq_pkg
module sortpq_dpath #(
    parameter int CAPACITY = sortpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sortpq_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sortpq_pkg::t_ctrl i_ctrl,
    output sortpq_pkg::t_stat o_stat,
    input  logic              i_cmd,
    input  logic [31:0]       i_key,
    output logic [31:0]       o_popped_key,
    output logic [1:0]        o_status,
    output logic [6:0]        o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] r_keys [CAPACITY];
    logic [KEY_BITS-1:0] n_keys [CAPACITY];
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [CAPACITY-1:0] w_le;
    logic [31:0]         r_popped_key, n_popped_key;
    logic [1:0]          r_status, n_status;
    logic [6:0]          r_entry_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
            r_key <= KEY_BITS'(i_key);
        end
    end

    // cells holding a key no greater than the new one form a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_keys[i] <= r_key);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_keys[i] = r_keys[i];
        end
        n_count      = r_count;
        n_popped_key = 32'd0;
        n_status     = sortpq_pkg::ST_OK;
        unique case (i_ctrl.op)
            sortpq_pkg::OP_INSERT: begin
                if (!w_le[0]) begin
                    n_keys[0] = r_key;
                end
                for (int i = 1; i < CAPACITY; i++) begin
                    if (!w_le[i]) begin
                        n_keys[i] = w_le[i-1] ? r_key : r_keys[i-1];
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
            sortpq_pkg::OP_EXTRACT: begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    n_keys[i] = r_keys[i+1];
                end
                n_count      = r_count - CNT_W'(1);
                n_popped_key = 32'(r_keys[0]);
            end
            sortpq_pkg::OP_REJECT_FULL:  n_status = sortpq_pkg::ST_FULL;
            sortpq_pkg::OP_REJECT_EMPTY: n_status = sortpq_pkg::ST_EMPTY;
            default: n_status = sortpq_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_keys[i] <= n_keys[i];
            end
            r_popped_key  <= n_popped_key;
            r_status      <= n_status;
            r_entry_count <= 7'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_count <= n_count;
        end
    end

    assign o_stat.cmd_extract = (r_cmd == sortpq_pkg::CMD_EXTRACT);
    assign o_stat.full        = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty       = (r_count == '0);

    assign o_popped_key  = r_popped_key;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

endmodule

// ----- src/sorted_priority_queue.sv -----
// sorted min-priority queue, shift-register sorted array of CAPACITY keys
// the load step registers the input; the execute step then writes the result register
// each transaction passes the load and execute steps of the controller, with no new item
// taken in between; the next item is taken once the output is empty or its result is read
// reset (synchronous, active low) empties the queue; stored keys are not cleared
// depends on sortpq_pkg, sortpq_ctrl, sortpq_dpath
module sorted_priority_queue #(
    parameter int CAPACITY = sortpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sortpq_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] key
    input  logic        i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] popped_key, [38:32] entry_count, [39] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    sortpq_pkg::t_ctrl w_ctrl;
    sortpq_pkg::t_stat w_stat;
    logic [31:0]       w_popped_key;
    logic [6:0]        w_entry_count;

    sortpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    sortpq_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_cmd         (i_s_tuser),
        .i_key         (i_s_tdata),
        .o_popped_key  (w_popped_key),
        .o_status      (o_m_tuser),
        .o_entry_count (w_entry_count)
    );

    assign o_m_tdata = {1'b0, w_entry_count, w_popped_key};

endmodule
